>>> rtl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg: shared definitions for the battery charge tracker
// Voltage limits, discharge curve points, divider constants and the
// status structs passed between the tracker modules.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int MV_W    = 13;   // filtered voltage width
  localparam int PCT_W   = 7;    // percent width
  localparam int SMP_W   = 16;   // raw sample width

  localparam logic [SMP_W-1:0] MIN_MV = 16'd2500;
  localparam logic [SMP_W-1:0] MAX_MV = 16'd4350;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_RECALC = 1'b1;

  localparam int TABLE_POINTS = 11;
  localparam int SEG_W        = 4;

  localparam logic [MV_W-1:0] VOLT_PTS [0:TABLE_POINTS-1] = '{
    13'd3300, 13'd3400, 13'd3500, 13'd3600, 13'd3650, 13'd3700,
    13'd3800, 13'd3900, 13'd4000, 13'd4100, 13'd4200
  };
  localparam logic [PCT_W-1:0] PCT_PTS [0:TABLE_POINTS-1] = '{
    7'd0, 7'd4, 7'd10, 7'd20, 7'd28, 7'd38, 7'd52, 7'd68, 7'd82, 7'd92, 7'd100
  };

  // Segments are 100 mV wide or 50 mV wide; 50 mV ones get the offset
  // doubled so a single divide by 100 serves both.
  localparam logic [MV_W-1:0] HALF_SPAN  = 13'd50;
  localparam logic [10:0]     ROUND_BIAS = 11'd50;
  // x / 100 == (x * 1311) >> 17 for x < 4681
  localparam logic [10:0]     RECIP_MUL   = 11'd1311;
  localparam int              RECIP_SHIFT = 17;

  localparam logic [PCT_W-1:0] LOW_THRESHOLD_RESET = 7'd10;
  localparam logic [PCT_W:0]   RELEASE_MARGIN      = 8'd3;

  localparam int FILTER_SHIFT = 3;   // filter gain 1/8

  typedef struct packed {
    logic            ready;
    logic [MV_W-1:0] avg_mv;
  } filt_state_t;

  typedef struct packed {
    logic             pct_ready;
    logic [PCT_W-1:0] pct;
    logic             low;
    logic             usb;
  } chg_state_t;

endpackage

>>> rtl/bct_filter.sv
// ----------------------------------------------------------------------------
// bct_filter: voltage sample range check and first-order filter
// Holds the filtered voltage; moves it by one eighth of the error per sample.
// ----------------------------------------------------------------------------
module bct_filter
  import bct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             kind,
  input  logic [SMP_W-1:0] sample_mv,
  output filt_state_t      filt,
  output filt_state_t      filt_nxt,
  output logic             sample_ok
);

  filt_state_t      filt_r;
  logic signed [13:0] diff;
  logic signed [13:0] step;
  logic [MV_W-1:0]    mv13;

  assign mv13      = sample_mv[MV_W-1:0];
  assign sample_ok = (kind == KIND_SAMPLE) && (sample_mv >= MIN_MV) && (sample_mv <= MAX_MV);

  assign diff = $signed({1'b0, mv13}) - $signed({1'b0, filt_r.avg_mv});

  // signed divide by 8, truncating toward zero
  always_comb begin
    if (diff < 0) begin
      step = (diff + 14'sd7) >>> FILTER_SHIFT;
    end else begin
      step = diff >>> FILTER_SHIFT;
    end
  end

  always_comb begin
    filt_nxt = filt_r;
    if (sample_ok) begin
      filt_nxt.ready = 1'b1;
      if (!filt_r.ready) begin
        filt_nxt.avg_mv = mv13;
      end else begin
        filt_nxt.avg_mv = filt_r.avg_mv + step[MV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (fire) begin
      filt_r <= filt_nxt;
    end
  end

  assign filt = filt_r;

endmodule

>>> rtl/bct_pct_map.sv
// ----------------------------------------------------------------------------
// bct_pct_map: filtered voltage to charge percent
// Piecewise-linear lookup over the discharge curve with rounded interpolation.
// ----------------------------------------------------------------------------
module bct_pct_map
  import bct_pkg::*;
(
  input  logic [MV_W-1:0]  mv,
  output logic [PCT_W-1:0] pct
);

  logic [SEG_W-1:0] seg;
  logic [SEG_W-1:0] seg_hi;
  logic [MV_W-1:0]  lo_v;
  logic [MV_W-1:0]  span;
  logic [MV_W-1:0]  off_full;
  logic [6:0]       off;
  logic [6:0]       off2;
  logic [4:0]       pspan;
  logic [10:0]      num;
  logic [21:0]      prod;
  logic [4:0]       quot;

  // segment whose lower point sits just below mv
  always_comb begin
    seg = '0;
    for (int j = 1; j < TABLE_POINTS - 1; j++) begin
      if (mv > VOLT_PTS[j]) seg = SEG_W'(j);
    end
  end

  assign seg_hi   = seg + SEG_W'(1);
  assign lo_v     = VOLT_PTS[seg];
  assign span     = VOLT_PTS[seg_hi] - lo_v;
  assign off_full = mv - lo_v;
  assign off      = off_full[6:0];
  assign off2     = (span == HALF_SPAN) ? {off[5:0], 1'b0} : off;
  assign pspan    = 5'(PCT_PTS[seg_hi] - PCT_PTS[seg]);
  assign num      = 11'(off2) * 11'(pspan) + ROUND_BIAS;
  assign prod     = {11'd0, num} * {11'd0, RECIP_MUL};
  assign quot     = prod[RECIP_SHIFT+4:RECIP_SHIFT];

  always_comb begin
    if (mv <= VOLT_PTS[0]) begin
      pct = PCT_PTS[0];
    end else if (mv >= VOLT_PTS[TABLE_POINTS-1]) begin
      pct = PCT_PTS[TABLE_POINTS-1];
    end else begin
      pct = PCT_PTS[seg] + {2'd0, quot};
    end
  end

endmodule

>>> rtl/bct_charge.sv
// ----------------------------------------------------------------------------
// bct_charge: charge estimate, low-battery flag and USB latch
// Updated on recalculate transactions only.
// ----------------------------------------------------------------------------
module bct_charge
  import bct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             kind,
  input  logic             usb_in,
  input  filt_state_t      filt,
  input  logic [PCT_W-1:0] low_thr,
  output chg_state_t       chg_nxt
);

  chg_state_t       chg_r;
  logic [PCT_W-1:0] cand;
  logic [PCT_W-1:0] pct_new;
  logic [PCT_W:0]   release_pt;

  bct_pct_map u_map (
    .mv  (filt.avg_mv),
    .pct (cand)
  );

  assign release_pt = {1'b0, low_thr} + RELEASE_MARGIN;

  // percent only falls unless on USB or no estimate yet
  assign pct_new = (!chg_r.pct_ready || usb_in || cand < chg_r.pct) ? cand : chg_r.pct;

  always_comb begin
    chg_nxt = chg_r;
    if (kind == KIND_RECALC) begin
      chg_nxt.usb = usb_in;
      if (filt.ready) begin
        chg_nxt.pct       = pct_new;
        chg_nxt.pct_ready = 1'b1;
        if (!chg_r.low && pct_new <= low_thr) begin
          chg_nxt.low = 1'b1;
        end else if (chg_r.low && {1'b0, pct_new} >= release_pt) begin
          chg_nxt.low = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_r <= '0;
    end else if (fire) begin
      chg_r <= chg_nxt;
    end
  end

endmodule

>>> rtl/battery_charge_tracker.sv
// ----------------------------------------------------------------------------
// battery_charge_tracker: battery state-of-charge tracker
// Filters voltage samples and turns the filtered voltage into a percent
// with a low-battery flag and a latched USB presence flag.
// ----------------------------------------------------------------------------
// Every input transaction gives exactly one result transaction showing the
// state after it. A transaction sits in the input register, is
// evaluated there by the filter and the curve lookup (one pass, no loop) and
// lands in the result register, so the block sustains one transaction per
// clock while out_ready stays high. While a result waits on out_ready the
// input register holds too, so at most two transactions sit in the block;
// in that case in_ready follows out_ready combinationally. Samples outside
// 2500..4350 mV leave everything alone and report sample_accepted low. The
// low-battery threshold (cfg port, always ready, resets to 10 %) is to be
// written by the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module battery_charge_tracker
  import bct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // threshold write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PCT_W-1:0] cfg_low_threshold_pct,
  // input transactions
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [SMP_W-1:0] in_sample_mv,
  input  logic             in_usb_in,
  // result transactions
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_sample_accepted,
  output logic             out_snapshot_valid,
  output logic [MV_W-1:0]  out_filtered_mv,
  output logic [PCT_W-1:0] out_charge_pct,
  output logic             out_low_flag,
  output logic             out_usb_flag
);

  // threshold register
  logic [PCT_W-1:0] low_thr_r;

  // input register
  logic             in_full_r;
  logic             kind_r;
  logic [SMP_W-1:0] mv_r;
  logic             usb_r;

  // result register
  logic             out_valid_r;
  logic             acc_r;
  filt_state_t      filt_out_r;
  chg_state_t       chg_out_r;

  logic             fire;      // input register moves into result register
  logic             sample_ok;
  filt_state_t      filt;
  filt_state_t      filt_nxt;
  chg_state_t       chg_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r <= LOW_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      low_thr_r <= cfg_low_threshold_pct;
    end
  end

  // stage advances when the result slot is free or being drained
  assign fire     = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ready) begin
      in_full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      mv_r   <= in_sample_mv;
      usb_r  <= in_usb_in;
    end
  end

  bct_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .kind      (kind_r),
    .sample_mv (mv_r),
    .filt      (filt),
    .filt_nxt  (filt_nxt),
    .sample_ok (sample_ok)
  );

  // recalc never touches the filter, so the current filter state is the
  // one the lookup must see
  bct_charge u_charge (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .kind    (kind_r),
    .usb_in  (usb_r),
    .filt    (filt),
    .low_thr (low_thr_r),
    .chg_nxt (chg_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r      <= sample_ok;
      filt_out_r <= filt_nxt;
      chg_out_r  <= chg_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_accepted = acc_r;
  assign out_snapshot_valid  = filt_out_r.ready;
  assign out_filtered_mv     = filt_out_r.avg_mv;
  assign out_charge_pct      = chg_out_r.pct;
  assign out_low_flag        = chg_out_r.low;
  assign out_usb_flag        = chg_out_r.usb;

endmodule
